// ===== src/scrolling_wrap_frame_buffer_defines.svh =====
// Assertion helpers for the scrolling frame buffer.
`ifndef SCROLLING_WRAP_FRAME_BUFFER_DEFINES_SVH
`define SCROLLING_WRAP_FRAME_BUFFER_DEFINES_SVH

// Check a property on every rising clock edge outside of reset.
`define SWFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define SWFB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== src/swfb_pkg.sv =====
`default_nettype none

package swfb_pkg;

  // Default store geometry
  localparam int DefMaxCols = 64;
  localparam int DefMaxRows = 64;

  // Field widths
  localparam int PixW   = 24;
  localparam int CoordW = 8;
  localparam int ColorW = 8;
  localparam int FuncW  = 2;
  localparam int SizeW  = 7;
  localparam int ScrollW = 9;
  localparam int CfgW   = 9;
  localparam int CfgIdxW = 3;
  localparam int MaxW   = 9;

  // Wrap unit: magnitude of a scrolled coordinate, one bit per step
  localparam int MagW     = 9;
  localparam int ModSteps = MagW;
  localparam int ModCntW  = $clog2(ModSteps);

  // Operation codes
  localparam logic [FuncW-1:0] FUNC_SET   = 2'd0;
  localparam logic [FuncW-1:0] FUNC_FILL  = 2'd1;
  localparam logic [FuncW-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FuncW-1:0] FUNC_READ  = 2'd3;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_CANVAS_WIDTH  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_CANVAS_HEIGHT = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SCROLL_X      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SCROLL_Y      = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_WRAP_X        = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_WRAP_Y        = 3'd5;

  // Register reset values
  localparam logic [SizeW-1:0] RST_CANVAS_WIDTH  = 7'd64;
  localparam logic [SizeW-1:0] RST_CANVAS_HEIGHT = 7'd32;

  // Request to the wrap unit
  typedef struct packed {
    logic             start;
    logic             neg;
    logic [MagW-1:0]  mag;
    logic [SizeW-1:0] size;
  } mod_req_t;

  // Clamp a size register to 1..maxv
  function automatic logic [SizeW-1:0] used_size(input logic [SizeW-1:0] r,
                                                 input logic [MaxW-1:0] maxv);
    logic [SizeW-1:0] s;
    s = r;
    if (s == '0) begin
      s = SizeW'(1);
    end
    if ({2'b00, s} > maxv) begin
      s = maxv[SizeW-1:0];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/scrolling_wrap_frame_buffer.sv =====
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------------------
// request  | in_valid_i / in_stall_o   | func_i, pos_x_i, pos_y_i, red/green/blue_in_i
// result   | out_valid_o / out_stall_i | disp_col_o, disp_row_o, drawn_o, red/green/blue_out_o
// config   | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// Set pixel writes at most one store entry; fill and clear sweep the whole store, one store entry
// written per cycle. A read passes the map, divide, read and data states, waiting in
// divide when an axis wraps outside the canvas (the bit-serial remainder unit, one bit of
// the 9-bit coordinate per cycle). After reset the store is cleared; requests stall
// meanwhile. A result waits in the output register while the next request is taken.
`default_nettype none

`include "scrolling_wrap_frame_buffer_defines.svh"

module scrolling_wrap_frame_buffer
  import swfb_pkg::*;
#(
  parameter int MAX_COLS = DefMaxCols,
  parameter int MAX_ROWS = DefMaxRows
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // configuration
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgW-1:0]     cfg_wdata_i,
  // request
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [FuncW-1:0]    func_i,
  input  wire logic [CoordW-1:0]   pos_x_i,
  input  wire logic [CoordW-1:0]   pos_y_i,
  input  wire logic [ColorW-1:0]   red_in_i,
  input  wire logic [ColorW-1:0]   green_in_i,
  input  wire logic [ColorW-1:0]   blue_in_i,
  // result
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [CoordW-1:0]   disp_col_o,
  output logic      [CoordW-1:0]   disp_row_o,
  output logic                     drawn_o,
  output logic      [ColorW-1:0]   red_out_o,
  output logic      [ColorW-1:0]   green_out_o,
  output logic      [ColorW-1:0]   blue_out_o
);

  localparam int Depth = MAX_COLS * MAX_ROWS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;

  // Controller states
  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SET   = 3'd2;
  localparam logic [2:0] S_MAP   = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_READ  = 3'd5;
  localparam logic [2:0] S_DATA  = 3'd6;

  logic [2:0]         state_q, state_d;

  // Configuration registers
  logic [SizeW-1:0]   width_q, height_q;
  logic [ScrollW-1:0] scroll_x_q, scroll_y_q;
  logic               wrap_x_q, wrap_y_q;

  // Request registers
  logic [CoordW-1:0]  px_q, py_q;
  logic [PixW-1:0]    color_q;
  logic [AddrW-1:0]   sweep_cnt_q;

  // Mapping registers
  logic [SizeW-1:0]   cx_q, cy_q;
  logic               okx_q, oky_q;
  logic               divx_q, divy_q;

  // Result registers
  logic               out_valid_q;
  logic [CoordW-1:0]  disp_col_q, disp_row_q;
  logic               drawn_q;
  logic [PixW-1:0]    pix_q;

  logic [SizeW-1:0]   w_used, h_used;
  logic signed [10:0] dx, dy;
  logic               inx, iny;
  logic [MagW-1:0]    magx, magy;
  mod_req_t           reqx, reqy;
  logic               busyx, busyy;
  logic [SizeW-1:0]   resx, resy;

  logic               in_acc, out_free;
  logic               set_ok;
  logic               ram_we, ram_re;
  logic [AddrW-1:0]   ram_waddr, ram_raddr;
  logic [PixW-1:0]    ram_wdata, ram_rdata;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Clamp canvas size to the store
  assign w_used = used_size(width_q, MaxW'(MAX_COLS));
  assign h_used = used_size(height_q, MaxW'(MAX_ROWS));

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= RST_CANVAS_WIDTH;
      height_q   <= RST_CANVAS_HEIGHT;
      scroll_x_q <= '0;
      scroll_y_q <= '0;
      wrap_x_q   <= 1'b0;
      wrap_y_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_CANVAS_WIDTH:  width_q    <= cfg_wdata_i[SizeW-1:0];
        REG_CANVAS_HEIGHT: height_q   <= cfg_wdata_i[SizeW-1:0];
        REG_SCROLL_X:      scroll_x_q <= cfg_wdata_i[ScrollW-1:0];
        REG_SCROLL_Y:      scroll_y_q <= cfg_wdata_i[ScrollW-1:0];
        REG_WRAP_X:        wrap_x_q   <= cfg_wdata_i[0];
        REG_WRAP_Y:        wrap_y_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Scrolled coordinates and their in-canvas test
  assign dx  = $signed({3'b000, px_q}) - $signed({{2{scroll_x_q[ScrollW-1]}}, scroll_x_q});
  assign dy  = $signed({3'b000, py_q}) - $signed({{2{scroll_y_q[ScrollW-1]}}, scroll_y_q});
  assign inx = !dx[10] && (dx[9:0] < {3'b000, w_used});
  assign iny = !dy[10] && (dy[9:0] < {3'b000, h_used});
  assign magx = dx[10] ? MagW'(-dx) : dx[MagW-1:0];
  assign magy = dy[10] ? MagW'(-dy) : dy[MagW-1:0];

  // Start the wrap units only for axes that fall outside and wrap
  always_comb begin
    reqx.start = (state_q == S_MAP) && !inx && wrap_x_q;
    reqx.neg   = dx[10];
    reqx.mag   = magx;
    reqx.size  = w_used;
    reqy.start = (state_q == S_MAP) && !iny && wrap_y_q;
    reqy.neg   = dy[10];
    reqy.mag   = magy;
    reqy.size  = h_used;
  end

  swfb_wrap_mod u_mod_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (reqx),
    .busy_o (busyx),
    .res_o  (resx)
  );

  swfb_wrap_mod u_mod_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (reqy),
    .busy_o (busyy),
    .res_o  (resy)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_SWEEP: begin
        if (sweep_cnt_q == AddrW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          case (func_i)
            FUNC_SET:   state_d = S_SET;
            FUNC_FILL:  state_d = S_SWEEP;
            FUNC_CLEAR: state_d = S_SWEEP;
            FUNC_READ:  state_d = S_MAP;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_SET:  state_d = S_IDLE;
      S_MAP:  state_d = S_DIV;
      S_DIV: begin
        if (!busyx && !busyy) begin
          state_d = S_READ;
        end
      end
      S_READ: state_d = S_DATA;
      S_DATA: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers; reset starts the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      sweep_cnt_q <= '0;
      color_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SWEEP) begin
        sweep_cnt_q <= sweep_cnt_q + AddrW'(1);
      end
      if (in_acc) begin
        sweep_cnt_q <= '0;
        color_q     <= (func_i == FUNC_CLEAR) ? '0 : {red_in_i, green_in_i, blue_in_i};
      end
    end
  end

  // Capture request coordinates
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
    end
  end

  // Map each axis, then take the wrapped values when the units finish
  always_ff @(posedge clk_i) begin
    if (state_q == S_MAP) begin
      okx_q  <= inx || wrap_x_q;
      oky_q  <= iny || wrap_y_q;
      divx_q <= !inx && wrap_x_q;
      divy_q <= !iny && wrap_y_q;
      cx_q   <= inx ? dx[SizeW-1:0] : '0;
      cy_q   <= iny ? dy[SizeW-1:0] : '0;
    end else if ((state_q == S_DIV) && !busyx && !busyy) begin
      if (divx_q) begin
        cx_q <= resx;
      end
      if (divy_q) begin
        cy_q <= resy;
      end
    end
  end

  // Store port: sweep or set on the write side, mapped pixel on the read side
  assign set_ok    = ({1'b0, px_q} < {2'b00, w_used}) && ({1'b0, py_q} < {2'b00, h_used});
  assign ram_we    = (state_q == S_SWEEP) || ((state_q == S_SET) && set_ok);
  assign ram_waddr = (state_q == S_SWEEP) ? sweep_cnt_q
                   : AddrW'(AddrW'(py_q) * AddrW'(MAX_COLS) + AddrW'(px_q));
  assign ram_wdata = color_q;
  assign ram_re    = (state_q == S_READ);
  assign ram_raddr = AddrW'(AddrW'(cy_q) * AddrW'(MAX_COLS) + AddrW'(cx_q));

  swfb_ram #(
    .WIDTH (PixW),
    .DEPTH (Depth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Output register: drop on take, load the finished read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DATA) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DATA) && out_free) begin
      disp_col_q <= px_q;
      disp_row_q <= py_q;
      drawn_q    <= okx_q && oky_q;
      pix_q      <= (okx_q && oky_q) ? ram_rdata : '0;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign disp_col_o  = disp_col_q;
  assign disp_row_o  = disp_row_q;
  assign drawn_o     = drawn_q;
  assign red_out_o   = pix_q[23:16];
  assign green_out_o = pix_q[15:8];
  assign blue_out_o  = pix_q[7:0];

  // Checks
  `SWFB_ASSERT(a_result_from_read, $rose(out_valid_o) |-> ($past(state_q) == S_DATA),
               "result appeared without a store read")
  `SWFB_ASSERT(a_undrawn_black, (out_valid_o && !drawn_o) |-> ((red_out_o == '0) && (green_out_o == '0) && (blue_out_o == '0)),
               "undrawn result carries a color")
  `SWFB_ASSERT(a_no_write_in_read, ((state_q == S_DIV) || (state_q == S_READ) || (state_q == S_DATA)) |-> !ram_we,
               "store written during a read")
  `SWFB_ASSERT_ALWAYS(a_sweep_stalls, (state_q == S_SWEEP) |-> in_stall_o,
                      "request taken during a sweep")

endmodule

`default_nettype wire

// ===== src/swfb_ram.sv =====
`default_nettype none

module swfb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read, hold when idle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/swfb_wrap_mod.sv =====
`default_nettype none

module swfb_wrap_mod
  import swfb_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire mod_req_t         req_i,
  output logic                  busy_o,
  output logic      [SizeW-1:0] res_o
);

  logic                busy_q;
  logic [ModCntW-1:0]  cnt_q;
  logic [MagW-1:0]     mag_q;
  logic [SizeW-1:0]    size_q;
  logic                neg_q;
  logic [SizeW-1:0]    rem_q;
  logic [SizeW:0]      trial;
  logic [SizeW-1:0]    rem_d;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, mag_q[MagW-1]};
    if (trial >= {1'b0, size_q}) begin
      rem_d = SizeW'(trial - {1'b0, size_q});
    end else begin
      rem_d = trial[SizeW-1:0];
    end
  end

  // Control: start loads operands, count up the steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == ModCntW'(ModSteps - 1)) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + ModCntW'(1);
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q  <= req_i.mag;
      size_q <= req_i.size;
      neg_q  <= req_i.neg;
      rem_q  <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[MagW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  // Fold a negative coordinate back to a non-negative remainder
  assign res_o  = (neg_q && (rem_q != '0)) ? SizeW'(size_q - rem_q) : rem_q;
  assign busy_o = busy_q;

endmodule

`default_nettype wire
